// File: sv/qfr_pkg.sv
// shared types and codes for the rotation matrix to quaternion block
package qfr_pkg;

	// signed fixed point value as carried on the channels
	typedef logic signed [15:0] fix_t;

	// sum of three entries and sum or difference of two entries
	typedef logic signed [17:0] sum_t;
	typedef logic signed [16:0] diff_t;

	localparam int DiffW = 17;

	// component taken from the square root
	typedef enum logic [1:0] {
		PART_W = 2'd0,
		PART_X = 2'd1,
		PART_Y = 2'd2,
		PART_Z = 2'd3
	} part_t;

	// input item: matrix entries, row then column
	typedef struct packed {
		fix_t m11;
		fix_t m12;
		fix_t m13;
		fix_t m21;
		fix_t m22;
		fix_t m23;
		fix_t m31;
		fix_t m32;
		fix_t m33;
	} mat_t;

	// result item: quaternion and the picked component
	typedef struct packed {
		fix_t       qw;
		fix_t       qx;
		fix_t       qy;
		fix_t       qz;
		logic [1:0] largest_part;
	} quat_t;

endpackage

// File: sv/qfr_if.sv
// valid/ready channel interfaces for matrix and quaternion items
interface qfr_mat_if;
	logic          valid;
	logic          ready;
	qfr_pkg::mat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qfr_quat_if;
	logic           valid;
	logic           ready;
	qfr_pkg::quat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/qfr_sqrt.sv
// pipelined integer square root, one root bit per stage
module qfr_sqrt #(
	parameter int NB = 15,
	parameter int SW = 53
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*NB-1:0] in_rad,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [NB-1:0]   out_root,
	output logic [SW-1:0]   out_side
);

	logic            v_s    [NB];
	logic [2*NB-1:0] rad_s  [NB];
	logic [NB+1:0]   rem_s  [NB];
	logic [NB-1:0]   root_s [NB];
	logic [SW-1:0]   side_s [NB];

	for (genvar k = 0; k < NB; k++) begin : g_stage
		logic            v_in;
		logic [2*NB-1:0] rad_in;
		logic [NB+1:0]   rem_in;
		logic [NB-1:0]   root_in;
		logic [SW-1:0]   side_in;
		logic [NB+1:0]   rem_sh;
		logic [NB+1:0]   trial;
		logic [NB+1:0]   rem_nx;
		logic [NB-1:0]   root_nx;

		// previous stage or the pipe input
		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rad_in  = in_rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		// bring down two radicand bits and try the next root bit
		always_comb begin
			rem_sh = {rem_in[NB-1:0], rad_in[2*NB-1 -: 2]};
			trial  = {root_in, 2'b01};
			if (rem_sh >= trial) begin
				rem_nx  = rem_sh - trial;
				root_nx = {root_in[NB-2:0], 1'b1};
			end else begin
				rem_nx  = rem_sh;
				root_nx = {root_in[NB-2:0], 1'b0};
			end
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_in << 2;
				rem_s[k]  <= rem_nx;
				root_s[k] <= root_nx;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = v_s[NB-1];
	assign out_root  = root_s[NB-1];
	assign out_side  = side_s[NB-1];

endmodule

// File: sv/qfr_div.sv
// three pipelined restoring dividers for d * 0.25 / big with rounding
module qfr_div #(
	parameter int F  = 14,
	parameter int NB = 15,
	parameter int NW = 32,
	parameter int SW = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [NB-1:0]        in_big,
	input  qfr_pkg::diff_t       in_d [3],
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	output logic [NB-1:0]        out_big,
	output logic [F:0]           out_q [3],
	output logic                 out_neg [3],
	output logic                 out_ov [3],
	output logic [SW-1:0]        out_side
);

	localparam int QB = F + 1;

	logic          v_s    [QB+1];
	logic [NB-1:0] big_s  [QB+1];
	logic [SW-1:0] side_s [QB+1];
	logic [NW-1:0] rem_s  [QB+1][3];
	logic [QB-1:0] q_s    [QB+1][3];
	logic          neg_s  [QB+1][3];
	logic          ov_s   [QB+1][3];

	// prep stage: magnitude, rounded numerator, overflow test
	logic [NW-1:0] den0;
	assign den0 = NW'({in_big, 2'b00});

	for (genvar l = 0; l < 3; l++) begin : g_prep
		logic [qfr_pkg::DiffW-1:0] mag;
		logic [NW-1:0]             num;

		always_comb begin
			mag = in_d[l][qfr_pkg::DiffW-1] ? qfr_pkg::DiffW'(-in_d[l])
				: qfr_pkg::DiffW'(in_d[l]);
			num = (NW'(mag) << F) + NW'({in_big, 1'b0});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0][l] <= num;
				q_s[0][l]   <= '0;
				neg_s[0][l] <= in_d[l][qfr_pkg::DiffW-1];
				ov_s[0][l]  <= num >= (den0 << QB);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s[0]  <= in_big;
			side_s[0] <= in_side;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int BitI = QB - 1 - j;
		logic [NW-1:0] den;

		assign den = NW'({big_s[j], 2'b00}) << BitI;

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [NW-1:0] rem_nx;
			logic [QB-1:0] q_nx;

			always_comb begin
				rem_nx = rem_s[j][l];
				q_nx   = q_s[j][l];
				if (rem_s[j][l] >= den) begin
					rem_nx     = rem_s[j][l] - den;
					q_nx[BitI] = 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1][l] <= rem_nx;
					q_s[j+1][l]   <= q_nx;
					neg_s[j+1][l] <= neg_s[j][l];
					ov_s[j+1][l]  <= ov_s[j][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				big_s[j+1]  <= big_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign out_big   = big_s[QB];
	assign out_side  = side_s[QB];

	for (genvar l = 0; l < 3; l++) begin : g_out
		assign out_q[l]   = q_s[QB][l];
		assign out_neg[l] = neg_s[QB][l];
		assign out_ov[l]  = ov_s[QB][l];
	end

endmodule

// File: sv/quaternion_from_rotation_matrix_core.sv
// Rotation matrix to unit quaternion converter, top level.
// Input channel mat carries one 3x3 matrix per item (signed, FRAC_BITS fraction
// bits); output channel quat carries the quaternion and the index of the
// component taken from the square root. Both are valid/ready channels.
// NB is the root width (half the bits of the shifted radicand).
// One item is accepted every cycle while the output does not stall;
// the depth is set by the root pipeline, one root bit per stage, and
// the divider lanes, one quotient bit per stage.
// All stages advance together: while a result waits in the output register
// and quat.ready is low, the whole pipeline holds and mat.ready is low; no
// item is lost or repeated. Reset clears every valid bit, so the pipeline
// comes up empty; there is no other state and no configuration.
// Non-rotation input is handled by raising the radicand to one LSB, and every
// output part saturates to plus or minus min(2^FRAC_BITS, 32767).
module quaternion_from_rotation_matrix_core #(
	parameter int FRAC_BITS = 14
) (
	input  logic       clk,
	input  logic       arst_n,
	qfr_mat_if.sink    mat,
	qfr_quat_if.source quat
);

	localparam int F    = FRAC_BITS;
	localparam int One  = 1 << F;
	localparam int RMax = One + 98304;
	localparam int RU   = $clog2(RMax + 1);
	localparam int RSW  = RU + 1;
	localparam int SNW  = RU + F - 2;
	localparam int NB   = (SNW + 1) / 2;
	localparam int RADW = 2 * NB;
	localparam int NW   = F + ((NB + 3 > 18) ? NB + 3 : 18);
	localparam int QB   = F + 1;
	localparam int Lim  = (One < 32767) ? One : 32767;
	localparam int DW   = qfr_pkg::DiffW;
	localparam int SQSW = 2 + 3 * DW;

	logic en;

	// global advance: output register free or being taken
	assign en        = !quat.valid || quat.ready;
	assign mat.ready = en;

	// stage 1: the four trace sums and the six entry pairs
	logic               v_s1;
	qfr_pkg::sum_t      sum_s1 [4];
	qfr_pkg::diff_t     dif_s1 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= mat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1[0] <= 18'(mat.data.m11) + 18'(mat.data.m22) + 18'(mat.data.m33);
			sum_s1[1] <= 18'(mat.data.m11) - 18'(mat.data.m22) - 18'(mat.data.m33);
			sum_s1[2] <= 18'(mat.data.m22) - 18'(mat.data.m11) - 18'(mat.data.m33);
			sum_s1[3] <= 18'(mat.data.m33) - 18'(mat.data.m11) - 18'(mat.data.m22);
			dif_s1[0] <= 17'(mat.data.m23) - 17'(mat.data.m32);
			dif_s1[1] <= 17'(mat.data.m31) - 17'(mat.data.m13);
			dif_s1[2] <= 17'(mat.data.m12) - 17'(mat.data.m21);
			dif_s1[3] <= 17'(mat.data.m12) + 17'(mat.data.m21);
			dif_s1[4] <= 17'(mat.data.m31) + 17'(mat.data.m13);
			dif_s1[5] <= 17'(mat.data.m23) + 17'(mat.data.m32);
		end
	end

	// stage 2: pick the largest sum (earlier wins ties), clamp the radicand
	qfr_pkg::part_t     p01, p23, pick;
	qfr_pkg::sum_t      b01, b23, best;
	logic signed [RSW-1:0] rsum;
	qfr_pkg::diff_t     lane [3];

	always_comb begin
		p01 = (sum_s1[1] > sum_s1[0]) ? qfr_pkg::PART_X : qfr_pkg::PART_W;
		b01 = (sum_s1[1] > sum_s1[0]) ? sum_s1[1] : sum_s1[0];
		p23 = (sum_s1[3] > sum_s1[2]) ? qfr_pkg::PART_Z : qfr_pkg::PART_Y;
		b23 = (sum_s1[3] > sum_s1[2]) ? sum_s1[3] : sum_s1[2];
		pick = (b23 > b01) ? p23 : p01;
		best = (b23 > b01) ? b23 : b01;
		rsum = RSW'(best) + RSW'(One);
		if (rsum < RSW'(1)) begin
			rsum = RSW'(1);
		end
	end

	// other three parts in ascending component order
	always_comb begin
		case (pick)
			qfr_pkg::PART_W: begin
				lane[0] = dif_s1[0];
				lane[1] = dif_s1[1];
				lane[2] = dif_s1[2];
			end
			qfr_pkg::PART_X: begin
				lane[0] = dif_s1[0];
				lane[1] = dif_s1[3];
				lane[2] = dif_s1[4];
			end
			qfr_pkg::PART_Y: begin
				lane[0] = dif_s1[1];
				lane[1] = dif_s1[3];
				lane[2] = dif_s1[5];
			end
			default: begin
				lane[0] = dif_s1[2];
				lane[1] = dif_s1[4];
				lane[2] = dif_s1[5];
			end
		endcase
	end

	logic               v_s2;
	logic [RU-1:0]      rad_s2;
	qfr_pkg::part_t     pick_s2;
	qfr_pkg::diff_t     lane_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2     <= RU'(rsum);
			pick_s2    <= pick;
			lane_s2[0] <= lane[0];
			lane_s2[1] <= lane[1];
			lane_s2[2] <= lane[2];
		end
	end

	// square root of the radicand shifted to the output format
	logic [RADW-1:0] sq_rad;
	logic            sq_valid;
	logic [NB-1:0]   sq_root;
	logic [SQSW-1:0] sq_side;

	assign sq_rad = RADW'(rad_s2) << (F - 2);

	qfr_sqrt #(
		.NB (NB),
		.SW (SQSW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_rad    (sq_rad),
		.in_side   ({pick_s2, lane_s2[0], lane_s2[1], lane_s2[2]}),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// divide the three pair sums and differences by four times the root
	qfr_pkg::diff_t dv_d [3];
	logic           dv_valid;
	logic [NB-1:0]  dv_big;
	logic [QB-1:0]  dv_q [3];
	logic           dv_neg [3];
	logic           dv_ov [3];
	logic [1:0]     dv_side;

	assign dv_d[0] = sq_side[3*DW-1 -: DW];
	assign dv_d[1] = sq_side[2*DW-1 -: DW];
	assign dv_d[2] = sq_side[DW-1:0];

	qfr_div #(
		.F  (F),
		.NB (NB),
		.NW (NW),
		.SW (2)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_big    (sq_root),
		.in_d      (dv_d),
		.in_side   (sq_side[SQSW-1 -: 2]),
		.out_valid (dv_valid),
		.out_big   (dv_big),
		.out_q     (dv_q),
		.out_neg   (dv_neg),
		.out_ov    (dv_ov),
		.out_side  (dv_side)
	);

	// saturate, apply signs and place the parts
	qfr_pkg::fix_t  lane_fix [3];
	qfr_pkg::fix_t  big_fix;
	qfr_pkg::fix_t  part [4];
	qfr_pkg::part_t out_pick;

	for (genvar l = 0; l < 3; l++) begin : g_sat
		logic [15:0] mag;

		always_comb begin
			if (dv_ov[l] || (dv_q[l] > QB'(Lim))) begin
				mag = 16'(Lim);
			end else begin
				mag = 16'(dv_q[l]);
			end
			lane_fix[l] = dv_neg[l] ? -$signed(mag) : $signed(mag);
		end
	end

	always_comb begin
		out_pick = qfr_pkg::part_t'(dv_side);
		big_fix  = (32'(dv_big) > 32'(Lim)) ? 16'(Lim) : 16'(dv_big);
		case (out_pick)
			qfr_pkg::PART_W: begin
				part[0] = big_fix;
				part[1] = lane_fix[0];
				part[2] = lane_fix[1];
				part[3] = lane_fix[2];
			end
			qfr_pkg::PART_X: begin
				part[0] = lane_fix[0];
				part[1] = big_fix;
				part[2] = lane_fix[1];
				part[3] = lane_fix[2];
			end
			qfr_pkg::PART_Y: begin
				part[0] = lane_fix[0];
				part[1] = lane_fix[1];
				part[2] = big_fix;
				part[3] = lane_fix[2];
			end
			default: begin
				part[0] = lane_fix[0];
				part[1] = lane_fix[1];
				part[2] = lane_fix[2];
				part[3] = big_fix;
			end
		endcase
	end

	// output register
	logic           ovld_q;
	qfr_pkg::quat_t quat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (en) begin
			ovld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_q.qw           <= part[0];
			quat_q.qx           <= part[1];
			quat_q.qy           <= part[2];
			quat_q.qz           <= part[3];
			quat_q.largest_part <= dv_side;
		end
	end

	assign quat.valid = ovld_q;
	assign quat.data  = quat_q;

`ifndef SYNTHESIS
	// the divisor entering the divider lanes is never zero
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid |-> sq_root != '0)
		else $error("square root result is zero");

	// the part taken from the square root is never negative
	a_big_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> !((quat.data.largest_part == qfr_pkg::PART_W && quat.data.qw[15]) ||
			(quat.data.largest_part == qfr_pkg::PART_X && quat.data.qx[15]) ||
			(quat.data.largest_part == qfr_pkg::PART_Y && quat.data.qy[15]) ||
			(quat.data.largest_part == qfr_pkg::PART_Z && quat.data.qz[15])))
		else $error("root component is negative");

	// w and x stay within the saturation limit
	a_wx_range: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> (quat.data.qw <= Lim && quat.data.qw >= -Lim &&
			quat.data.qx <= Lim && quat.data.qx >= -Lim))
		else $error("w or x beyond limit");

	// y and z stay within the saturation limit
	a_yz_range: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> (quat.data.qy <= Lim && quat.data.qy >= -Lim &&
			quat.data.qz <= Lim && quat.data.qz >= -Lim))
		else $error("y or z beyond limit");
`endif

endmodule

// File: bench/tb_quaternion_from_rotation_matrix_core.sv
// testbench for the rotation matrix to quaternion converter
`timescale 1ns / 100ps

module tb_quaternion_from_rotation_matrix_core;

	localparam int FracBits = 14;
	localparam int Latency = 34;
	localparam longint CycleLimit = 400000;
	localparam int RandomItems = 1800;

	// scoreboard: predicts each quaternion and checks results in order
	class quat_scoreboard;
		qfr_pkg::quat_t pending[$];
		int errors;

		function longint clamp_part(longint v);
			longint lim;
			lim = (64'sd1 <<< FracBits) < 32767 ? (64'sd1 <<< FracBits) : 32767;
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		function longint root_floor(longint n);
			longint r;
			r = 0;
			while ((r + 1) * (r + 1) <= n) r = r + 1;
			return r;
		endfunction

		// d * 0.25 / big, magnitude rounded half away from zero
		function longint quarter_div(longint d, longint big);
			longint mag, q;
			mag = (d < 0 ? -d : d) <<< FracBits;
			q = (mag + (big <<< 1)) / (big <<< 2);
			return clamp_part(d < 0 ? -q : q);
		endfunction

		function void note_matrix(qfr_pkg::mat_t m);
			longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
			longint s[4];
			longint r, big;
			int pick;
			qfr_pkg::quat_t q;
			a11 = longint'(m.m11); a12 = longint'(m.m12); a13 = longint'(m.m13);
			a21 = longint'(m.m21); a22 = longint'(m.m22); a23 = longint'(m.m23);
			a31 = longint'(m.m31); a32 = longint'(m.m32); a33 = longint'(m.m33);
			s[0] = a11 + a22 + a33;
			s[1] = a11 - a22 - a33;
			s[2] = a22 - a11 - a33;
			s[3] = a33 - a11 - a22;
			pick = 0;
			for (int i = 1; i < 4; i++)
				if (s[i] > s[pick]) pick = i;
			r = s[pick] + (64'sd1 <<< FracBits);
			if (r < 1) r = 1;
			big = root_floor(r <<< (FracBits - 2));
			if (big < 1) big = 1;
			case (pick)
				0: begin
					q.qw = qfr_pkg::fix_t'(clamp_part(big));
					q.qx = qfr_pkg::fix_t'(quarter_div(a23 - a32, big));
					q.qy = qfr_pkg::fix_t'(quarter_div(a31 - a13, big));
					q.qz = qfr_pkg::fix_t'(quarter_div(a12 - a21, big));
					q.largest_part = qfr_pkg::PART_W;
				end
				1: begin
					q.qx = qfr_pkg::fix_t'(clamp_part(big));
					q.qw = qfr_pkg::fix_t'(quarter_div(a23 - a32, big));
					q.qy = qfr_pkg::fix_t'(quarter_div(a12 + a21, big));
					q.qz = qfr_pkg::fix_t'(quarter_div(a31 + a13, big));
					q.largest_part = qfr_pkg::PART_X;
				end
				2: begin
					q.qy = qfr_pkg::fix_t'(clamp_part(big));
					q.qw = qfr_pkg::fix_t'(quarter_div(a31 - a13, big));
					q.qx = qfr_pkg::fix_t'(quarter_div(a12 + a21, big));
					q.qz = qfr_pkg::fix_t'(quarter_div(a23 + a32, big));
					q.largest_part = qfr_pkg::PART_Y;
				end
				default: begin
					q.qz = qfr_pkg::fix_t'(clamp_part(big));
					q.qw = qfr_pkg::fix_t'(quarter_div(a12 - a21, big));
					q.qx = qfr_pkg::fix_t'(quarter_div(a31 + a13, big));
					q.qy = qfr_pkg::fix_t'(quarter_div(a23 + a32, big));
					q.largest_part = qfr_pkg::PART_Z;
				end
			endcase
			pending.push_back(q);
		endfunction

		function void check_quat(qfr_pkg::quat_t got);
			qfr_pkg::quat_t exp_q;
			if (pending.size() == 0) begin
				$error("unexpected quaternion item %h", got);
				errors++;
				return;
			end
			exp_q = pending.pop_front();
			if (got.qw !== exp_q.qw) begin
				$error("qw expected %0d actual %0d", exp_q.qw, got.qw);
				errors++;
			end
			if (got.qx !== exp_q.qx) begin
				$error("qx expected %0d actual %0d", exp_q.qx, got.qx);
				errors++;
			end
			if (got.qy !== exp_q.qy) begin
				$error("qy expected %0d actual %0d", exp_q.qy, got.qy);
				errors++;
			end
			if (got.qz !== exp_q.qz) begin
				$error("qz expected %0d actual %0d", exp_q.qz, got.qz);
				errors++;
			end
			if (got.largest_part !== exp_q.largest_part) begin
				$error("largest_part expected %0d actual %0d",
					exp_q.largest_part, got.largest_part);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	longint cycles;
	bit idle_off;
	quat_scoreboard board;

	qfr_mat_if mat ();
	qfr_quat_if quat ();

	quaternion_from_rotation_matrix_core #(.FRAC_BITS(FracBits)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.mat(mat),
		.quat(quat)
	);

	// clock and cycle limit
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random ready stalls and checking
	initial begin
		int hold;
		quat.ready = 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (quat.valid && quat.ready) board.check_quat(quat.data);
			if (hold > 0) begin
				hold--;
				quat.ready <= 1'b0;
			end else if (!idle_off && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 11) - 1;
				quat.ready <= 1'b0;
			end else begin
				quat.ready <= 1'b1;
			end
		end
	end

	function automatic qfr_pkg::fix_t rand_entry();
		case ($urandom_range(0, 9))
			0: return qfr_pkg::fix_t'($urandom);
			1: return 16'sd16384;
			2: return -16'sd16384;
			3: return qfr_pkg::fix_t'($urandom_range(0, 32) - 16);
			default: return qfr_pkg::fix_t'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// well-formed rotation about one axis by a random angle
	function automatic qfr_pkg::mat_t rand_rotation();
		qfr_pkg::mat_t m;
		qfr_pkg::fix_t c, s;
		int ang;
		real th;
		th = ($urandom_range(0, 3600) / 3600.0) * 6.283185307;
		c = qfr_pkg::fix_t'($rtoi($cos(th) * 16384.0));
		s = qfr_pkg::fix_t'($rtoi($sin(th) * 16384.0));
		m = '0;
		ang = $urandom_range(0, 2);
		case (ang)
			0: begin
				m.m11 = 16'sd16384; m.m22 = c; m.m23 = -s; m.m32 = s; m.m33 = c;
			end
			1: begin
				m.m22 = 16'sd16384; m.m11 = c; m.m13 = s; m.m31 = -s; m.m33 = c;
			end
			default: begin
				m.m33 = 16'sd16384; m.m11 = c; m.m12 = -s; m.m21 = s; m.m22 = c;
			end
		endcase
		return m;
	endfunction

	task automatic send_matrix(qfr_pkg::mat_t m);
		mat.valid <= 1'b1;
		mat.data <= m;
		do @(posedge clk); while (!mat.ready);
		board.note_matrix(m);
		if (!idle_off && $urandom_range(0, 7) == 0) begin
			mat.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send_entries(qfr_pkg::fix_t a, qfr_pkg::fix_t b, qfr_pkg::fix_t c,
			qfr_pkg::fix_t d, qfr_pkg::fix_t e, qfr_pkg::fix_t f,
			qfr_pkg::fix_t g, qfr_pkg::fix_t h, qfr_pkg::fix_t k);
		qfr_pkg::mat_t m;
		m.m11 = a; m.m12 = b; m.m13 = c;
		m.m21 = d; m.m22 = e; m.m23 = f;
		m.m31 = g; m.m32 = h; m.m33 = k;
		send_matrix(m);
	endtask

	task automatic drain();
		mat.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		qfr_pkg::mat_t m;
		board = new();
		cycles = 0;
		idle_off = 1'b0;
		arst_n = 1'b0;
		mat.valid = 1'b0;
		mat.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity and the three half turns pick each component
		send_entries(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
		send_entries(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
		send_entries(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
		send_entries(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
		// ties between sums: earlier index wins
		send_entries(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_entries(0, 16384, 0, 16384, 0, 0, 0, 0, -16384);
		// non-rotation input: negated identity and a full-scale matrix
		send_entries(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
		send_entries(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
		// output overflow on the divided parts
		send_entries(-16384, 32767, -32768, -32768, -16384, 32767, 32767, -32768, -16384);
		send_entries(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_entries(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000);
		send_entries(16'shffff, 16'sh5555, 16'shaaaa, 16'sh0001, 16'shffff,
			16'sh5555, 16'shaaaa, 16'sh0001, 16'shffff);
		// quarter turns
		send_entries(16384, 0, 0, 0, 0, -16384, 0, 16384, 0);
		send_entries(0, 0, 16384, 0, 16384, 0, -16384, 0, 0);
		send_entries(0, -16384, 0, 16384, 0, 0, 0, 0, 16384);

		// let the pipeline empty before the random part
		drain();

		for (int n = 0; n < RandomItems; n++) begin
			if (n == RandomItems - 200) idle_off = 1'b1;
			if ($urandom_range(0, 3) != 0) begin
				m = rand_rotation();
				if ($urandom_range(0, 3) == 0)
					m.m12 = m.m12 + qfr_pkg::fix_t'($urandom_range(0, 6) - 3);
			end else begin
				m.m11 = rand_entry(); m.m12 = rand_entry(); m.m13 = rand_entry();
				m.m21 = rand_entry(); m.m22 = rand_entry(); m.m23 = rand_entry();
				m.m31 = rand_entry(); m.m32 = rand_entry(); m.m33 = rand_entry();
			end
			send_matrix(m);
		end
		drain();
		repeat (Latency + 10) @(posedge clk);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: quaternion_from_rotation_matrix_core.f
sv/qfr_pkg.sv
sv/qfr_if.sv
sv/qfr_sqrt.sv
sv/qfr_div.sv
sv/quaternion_from_rotation_matrix_core.sv
bench/tb_quaternion_from_rotation_matrix_core.sv
